// ===== rtl/lfcs_pkg.sv =====
// lfcs_pkg: command/status types and operation codes shared by the
// line fit chi-square controller, datapath and top level. no dependencies.
`timescale 1ns / 1ps
package lfcs_pkg;

  localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q_CAP   = 64'h0000_0001_0000_0000;
  localparam logic [49:0] CHI_MAX = 50'h0_FFFF_FFFF_FFFF;

  typedef logic [2:0] acc_op_t;
  localparam acc_op_t ACC_NOP   = 3'd0;
  localparam acc_op_t ACC_LD    = 3'd1;
  localparam acc_op_t ACC_ADD   = 3'd2;
  localparam acc_op_t ACC_SUB   = 3'd3;
  localparam acc_op_t ACC_ADDMQ = 3'd4;
  localparam acc_op_t ACC_SUBMQ = 3'd5;

  typedef logic [2:0] src_t;
  localparam src_t SRC_ONE = 3'd0;
  localparam src_t SRC_X   = 3'd1;
  localparam src_t SRC_Y   = 3'd2;
  localparam src_t SRC_Z   = 3'd3;
  localparam src_t SRC_BX  = 3'd4;
  localparam src_t SRC_BY  = 3'd5;
  localparam src_t SRC_F   = 3'd6;

  typedef logic [1:0] mul_op_t;
  localparam mul_op_t MUL_NOP = 2'd0;
  localparam mul_op_t MUL_LO  = 2'd1;
  localparam mul_op_t MUL_HI  = 2'd2;

  typedef logic [2:0] a_sel_t;
  localparam a_sel_t A_X  = 3'd0;
  localparam a_sel_t A_Y  = 3'd1;
  localparam a_sel_t A_BX = 3'd2;
  localparam a_sel_t A_BY = 3'd3;
  localparam a_sel_t A_AX = 3'd4;
  localparam a_sel_t A_AY = 3'd5;
  localparam a_sel_t A_F  = 3'd6;
  localparam a_sel_t A_Q  = 3'd7;

  typedef logic [1:0] b_sel_t;
  localparam b_sel_t B_AX = 2'd0;
  localparam b_sel_t B_AY = 2'd1;
  localparam b_sel_t B_Q  = 2'd2;

  typedef logic [2:0] div_op_t;
  localparam div_op_t DIV_NOP = 3'd0;
  localparam div_op_t DIV_F   = 3'd1;
  localparam div_op_t DIV_TX  = 3'd2;
  localparam div_op_t DIV_TY  = 3'd3;
  localparam div_op_t DIV_TZ  = 3'd4;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SLOPE_X  = 2'd0;
  localparam reg_idx_t REG_OFFSET_X = 2'd1;
  localparam reg_idx_t REG_SLOPE_Y  = 2'd2;
  localparam reg_idx_t REG_OFFSET_Y = 2'd3;

  typedef struct packed {
    acc_op_t acc_op;
    src_t    src;
    mul_op_t mul_op;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    div_op_t div_op;
    logic    den_ld;
    logic    f_ld;
    logic    sum_add;
    logic    load_in;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

// ===== rtl/lfcs_div.sv =====
// lfcs_div: serial restoring divider, one quotient bit per cycle,
// computes min(n * 2^16 / den, cap). no dependencies.
`timescale 1ns / 1ps
module lfcs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] n,
  input  logic [63:0] den,
  input  logic [63:0] cap,
  output logic        busy,
  output logic [63:0] q
);
  logic [78:0] nsh_r;
  logic [63:0] rem_r, quo_r, den_r, cap_r;
  logic        ovf_r, busy_r;
  logic [6:0]  cnt_r;
  logic [63:0] rs, qs;
  logic        ge;

  always_comb begin
    rs = {rem_r[62:0], nsh_r[78]};
    ge = (rs >= den_r);
    qs = {quo_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 7'd0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh_r <= {n, 16'b0};
      rem_r <= '0;
      quo_r <= '0;
      den_r <= den;
      cap_r <= cap;
      ovf_r <= 1'b0;
      cnt_r <= 7'd78;
    end else if (busy_r) begin
      nsh_r <= {nsh_r[77:0], 1'b0};
      rem_r <= ge ? rs - den_r : rs;
      cnt_r <= cnt_r - 7'd1;
      // once past the cap the result is pinned, stop tracking the quotient
      if (!ovf_r) begin
        if (qs > cap_r) ovf_r <= 1'b1;
        else quo_r <= qs;
      end
    end
  end

  assign busy = busy_r;
  assign q    = ovf_r ? cap_r : quo_r;
endmodule

// ===== rtl/lfcs_dp.sv =====
// lfcs_dp: datapath with track registers, hit registers, shared multiplier,
// accumulator, running sum state and result registers. uses lfcs_pkg, lfcs_div.
`timescale 1ns / 1ps
module lfcs_dp #(
  parameter int MAX_HITS = 1024,
  parameter int CNT_W    = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfcs_pkg::cmd_t      cmd,
  output lfcs_pkg::status_t   status,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  input  logic signed [31:0]  in_hit_x,
  input  logic signed [31:0]  in_hit_y,
  input  logic signed [31:0]  in_hit_z,
  input  logic [31:0]         in_sigma_x,
  input  logic [31:0]         in_sigma_y,
  input  logic [31:0]         in_sigma_z,
  input  logic                in_last_hit,
  output logic [47:0]         out_chi_square,
  output logic                out_is_last,
  output logic                out_sum_saturated,
  output logic                out_too_many_hits
);
  import lfcs_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HITS);

  logic signed [31:0] ax_r, bx_r, ay_r, by_r;
  logic signed [31:0] hx_r, hy_r, hz_r;
  logic [31:0]        sx_r, sy_r, sz_r;
  logic               last_r;
  logic signed [63:0] acc_r, f_r;
  logic [63:0]        den_r;
  logic               fneg_r;
  logic [63:0]        plo_r;
  logic [62:0]        phi_r;
  logic               neg_r;
  logic [49:0]        sum_r;
  logic               satt_r;
  logic [47:0]        chi_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               satf_r;

  logic signed [63:0] a_val, b_val, a_abs, b_abs, srcv, acc_abs;
  logic [62:0]        ua;
  logic [31:0]        ub;
  logic               mneg;
  logic [63:0]        mq, mq_sum;
  logic [63:0]        div_q, div_den, div_cap;
  logic [62:0]        div_n;
  logic               div_start, div_busy;
  logic [31:0]        sig;
  logic               over;
  logic [CNT_W-1:0]   cnt_new;

  always_comb begin
    case (cmd.a_sel)
      A_X:     a_val = 64'(hx_r);
      A_Y:     a_val = 64'(hy_r);
      A_BX:    a_val = 64'(bx_r);
      A_BY:    a_val = 64'(by_r);
      A_AX:    a_val = 64'(ax_r);
      A_AY:    a_val = 64'(ay_r);
      A_F:     a_val = f_r;
      default: a_val = {32'b0, div_q[31:0]};
    endcase
    case (cmd.b_sel)
      B_AX:    b_val = 64'(ax_r);
      B_AY:    b_val = 64'(ay_r);
      default: b_val = {32'b0, div_q[31:0]};
    endcase
    a_abs = a_val[63] ? -a_val : a_val;
    b_abs = b_val[63] ? -b_val : b_val;
    ua    = a_abs[62:0];
    ub    = b_abs[31:0];
    mneg  = a_val[63] ^ b_val[63];

    // q16.16 product magnitude, clamped
    mq_sum = {phi_r[45:0], 16'b0} + {16'b0, plo_r[63:16]};
    if (phi_r[62:46] != '0) mq = MAG_CAP;
    else if (mq_sum > MAG_CAP) mq = MAG_CAP;
    else mq = mq_sum;

    case (cmd.src)
      SRC_ONE: srcv = 64'sd65536;
      SRC_X:   srcv = 64'(hx_r);
      SRC_Y:   srcv = 64'(hy_r);
      SRC_Z:   srcv = 64'(hz_r);
      SRC_BX:  srcv = 64'(bx_r);
      SRC_BY:  srcv = 64'(by_r);
      default: srcv = f_r;
    endcase

    acc_abs = acc_r[63] ? -acc_r : acc_r;
    div_n   = (acc_abs > MAG_CAP) ? MAG_CAP[62:0] : acc_abs[62:0];
    case (cmd.div_op)
      DIV_TX:  sig = sx_r;
      DIV_TY:  sig = sy_r;
      default: sig = sz_r;
    endcase
    div_start = (cmd.div_op != DIV_NOP);
    if (cmd.div_op == DIV_F) begin
      div_den = den_r;
      div_cap = MAG_CAP;
    end else begin
      div_den = (sig == 32'd0) ? 64'd1 : {32'b0, sig};
      div_cap = Q_CAP;
    end

    over    = satt_r || (sum_r > CHI_MAX);
    cnt_new = (cnt_r <= MAX_CNT) ? cnt_r + 1'b1 : cnt_r;
  end

  lfcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .den   (div_den),
    .cap   (div_cap),
    .busy  (div_busy),
    .q     (div_q)
  );

  assign status.div_busy = div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      bx_r <= '0;
      ay_r <= '0;
      by_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SLOPE_X:  ax_r <= cfg_wdata;
        REG_OFFSET_X: bx_r <= cfg_wdata;
        REG_SLOPE_Y:  ay_r <= cfg_wdata;
        REG_OFFSET_Y: by_r <= cfg_wdata;
        default:      ax_r <= ax_r;
      endcase
    end
  end

  // track state: cleared after the transaction that closes the track
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chi_r  <= '0;
      cnt_r  <= '0;
      satf_r <= 1'b0;
    end else if (cmd.finish) begin
      if (last_r) begin
        chi_r  <= '0;
        cnt_r  <= '0;
        satf_r <= 1'b0;
      end else begin
        chi_r  <= over ? CHI_MAX[47:0] : sum_r[47:0];
        cnt_r  <= cnt_new;
        satf_r <= satf_r | over;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hx_r   <= in_hit_x;
      hy_r   <= in_hit_y;
      hz_r   <= in_hit_z;
      sx_r   <= in_sigma_x;
      sy_r   <= in_sigma_y;
      sz_r   <= in_sigma_z;
      last_r <= in_last_hit;
      sum_r  <= {2'b0, chi_r};
      satt_r <= 1'b0;
    end
    if (cmd.mul_op == MUL_LO) begin
      plo_r <= 64'(ua[31:0]) * 64'(ub);
      neg_r <= mneg;
    end
    if (cmd.mul_op == MUL_HI) phi_r <= 63'(ua[62:32]) * 63'(ub);
    case (cmd.acc_op)
      ACC_LD:    acc_r <= srcv;
      ACC_ADD:   acc_r <= acc_r + srcv;
      ACC_SUB:   acc_r <= acc_r - srcv;
      ACC_ADDMQ: acc_r <= neg_r ? acc_r - mq : acc_r + mq;
      ACC_SUBMQ: acc_r <= neg_r ? acc_r + mq : acc_r - mq;
      default:   acc_r <= acc_r;
    endcase
    if (cmd.den_ld) den_r <= acc_r;
    if (cmd.div_op == DIV_F) fneg_r <= acc_r[63];
    if (cmd.f_ld) f_r <= fneg_r ? -div_q : div_q;
    if (cmd.sum_add) begin
      // a capped ratio saturates the whole term
      if (div_q[63:32] != '0) satt_r <= 1'b1;
      else sum_r <= sum_r + mq[49:0];
    end
    if (cmd.finish) begin
      out_chi_square    <= over ? CHI_MAX[47:0] : sum_r[47:0];
      out_is_last       <= last_r;
      out_sum_saturated <= satf_r | over;
      out_too_many_hits <= (cnt_new > MAX_CNT);
    end
  end
endmodule

// ===== rtl/lfcs_ctrl.sv =====
// lfcs_ctrl: sequencer that steps the datapath through one hit and runs
// the input and result handshakes. uses lfcs_pkg.
`timescale 1ns / 1ps
module lfcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lfcs_pkg::status_t status,
  output lfcs_pkg::cmd_t    cmd
);
  import lfcs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [5:0] LAST_STEP = 6'd50;

  logic       state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;
  logic       wait_div;

  always_comb begin
    cmd       = '0;
    wait_div  = 1'b0;
    state_nxt = state_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r & ~out_ready;
    in_ready  = (state_r == ST_IDLE);
    if (state_r == ST_IDLE) begin
      if (in_valid) begin
        cmd.load_in = 1'b1;
        state_nxt   = ST_RUN;
        step_nxt    = 6'd0;
      end
    end else begin
      case (step_r)
        // direction length squared: 1 + ax*ax + ay*ay
        6'd0:  begin cmd.acc_op = ACC_LD; cmd.src = SRC_ONE; end
        6'd1:  begin cmd.mul_op = MUL_LO; cmd.a_sel = A_AX; cmd.b_sel = B_AX; end
        6'd2:  begin cmd.mul_op = MUL_HI; cmd.a_sel = A_AX; cmd.b_sel = B_AX; end
        6'd3:  cmd.acc_op = ACC_ADDMQ;
        6'd4:  begin cmd.mul_op = MUL_LO; cmd.a_sel = A_AY; cmd.b_sel = B_AY; end
        6'd5:  begin cmd.mul_op = MUL_HI; cmd.a_sel = A_AY; cmd.b_sel = B_AY; end
        6'd6:  cmd.acc_op = ACC_ADDMQ;
        6'd7:  begin cmd.den_ld = 1'b1; cmd.acc_op = ACC_LD; cmd.src = SRC_Z; end
        // numerator: x*ax + y*ay + z - bx*ax - by*ay
        6'd8:  begin cmd.mul_op = MUL_LO; cmd.a_sel = A_X; cmd.b_sel = B_AX; end
        6'd9:  begin cmd.mul_op = MUL_HI; cmd.a_sel = A_X; cmd.b_sel = B_AX; end
        6'd10: cmd.acc_op = ACC_ADDMQ;
        6'd11: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_Y; cmd.b_sel = B_AY; end
        6'd12: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_Y; cmd.b_sel = B_AY; end
        6'd13: cmd.acc_op = ACC_ADDMQ;
        6'd14: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_BX; cmd.b_sel = B_AX; end
        6'd15: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_BX; cmd.b_sel = B_AX; end
        6'd16: cmd.acc_op = ACC_SUBMQ;
        6'd17: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_BY; cmd.b_sel = B_AY; end
        6'd18: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_BY; cmd.b_sel = B_AY; end
        6'd19: cmd.acc_op = ACC_SUBMQ;
        6'd20: cmd.div_op = DIV_F;
        6'd21: wait_div = 1'b1;
        6'd22: cmd.f_ld = 1'b1;
        // x residual
        6'd23: begin cmd.acc_op = ACC_LD; cmd.src = SRC_BX; end
        6'd24: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_F; cmd.b_sel = B_AX; end
        6'd25: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_F; cmd.b_sel = B_AX; end
        6'd26: cmd.acc_op = ACC_ADDMQ;
        6'd27: begin cmd.acc_op = ACC_SUB; cmd.src = SRC_X; end
        6'd28: cmd.div_op = DIV_TX;
        6'd29: wait_div = 1'b1;
        6'd30: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_Q; cmd.b_sel = B_Q; end
        6'd31: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_Q; cmd.b_sel = B_Q; end
        6'd32: cmd.sum_add = 1'b1;
        // y residual
        6'd33: begin cmd.acc_op = ACC_LD; cmd.src = SRC_BY; end
        6'd34: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_F; cmd.b_sel = B_AY; end
        6'd35: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_F; cmd.b_sel = B_AY; end
        6'd36: cmd.acc_op = ACC_ADDMQ;
        6'd37: begin cmd.acc_op = ACC_SUB; cmd.src = SRC_Y; end
        6'd38: cmd.div_op = DIV_TY;
        6'd39: wait_div = 1'b1;
        6'd40: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_Q; cmd.b_sel = B_Q; end
        6'd41: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_Q; cmd.b_sel = B_Q; end
        6'd42: cmd.sum_add = 1'b1;
        // z residual
        6'd43: begin cmd.acc_op = ACC_LD; cmd.src = SRC_F; end
        6'd44: begin cmd.acc_op = ACC_SUB; cmd.src = SRC_Z; end
        6'd45: cmd.div_op = DIV_TZ;
        6'd46: wait_div = 1'b1;
        6'd47: begin cmd.mul_op = MUL_LO; cmd.a_sel = A_Q; cmd.b_sel = B_Q; end
        6'd48: begin cmd.mul_op = MUL_HI; cmd.a_sel = A_Q; cmd.b_sel = B_Q; end
        6'd49: cmd.sum_add = 1'b1;
        default: cmd = '0;
      endcase
      if (step_r == LAST_STEP) begin
        // hold until the previous result has been taken
        if (!ov_r) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end else if (!(wait_div && status.div_busy)) begin
        step_nxt = step_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule

// ===== rtl/line_fit_chi_square.sv =====
// line_fit_chi_square: top level, joins sequencer and datapath and checks
// a few internal properties. uses lfcs_pkg, lfcs_ctrl, lfcs_dp.
`timescale 1ns / 1ps
// Scores 3D hits against the straight track set in the four configuration
// registers and returns the running chi-square of the track after every hit.
// One hit is taken at a time and is through before the next is accepted.
// Its result needs four serial divisions (projection factor and the three
// residual ratios) on one shared divider, plus 51 sequencer steps for the
// multiplies and sums. The next hit can be accepted in the same cycle as
// the result appears. A new hit is accepted while the previous result still
// waits on the output; the sequence holds at its last step only if that
// result has not been taken by then. A hit with last_hit set closes the
// track and clears the sum, the hit count and the saturation flag.
// Configuration writes must only be made while no hit is in flight; the
// block itself does not enforce this.
module line_fit_chi_square #(
  parameter int MAX_HITS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_hit_x,
  input  logic signed [31:0] in_hit_y,
  input  logic signed [31:0] in_hit_z,
  input  logic [31:0]        in_sigma_x,
  input  logic [31:0]        in_sigma_y,
  input  logic [31:0]        in_sigma_z,
  input  logic               in_last_hit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        out_chi_square,
  output logic               out_is_last,
  output logic               out_sum_saturated,
  output logic               out_too_many_hits,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import lfcs_pkg::*;

  localparam int CNT_W = $clog2(MAX_HITS + 2);

  cmd_t    cmd;
  status_t status;

  lfcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfcs_dp #(
    .MAX_HITS (MAX_HITS),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_hit_x          (in_hit_x),
    .in_hit_y          (in_hit_y),
    .in_hit_z          (in_hit_z),
    .in_sigma_x        (in_sigma_x),
    .in_sigma_y        (in_sigma_y),
    .in_sigma_z        (in_sigma_z),
    .in_last_hit       (in_last_hit),
    .out_chi_square    (out_chi_square),
    .out_is_last       (out_is_last),
    .out_sum_saturated (out_sum_saturated),
    .out_too_many_hits (out_too_many_hits)
  );

  // an accepted transaction keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a hit is in flight");

  // a saturated track always reports the full-scale sum
  a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sum_saturated |-> out_chi_square == CHI_MAX[47:0])
    else $error("saturated result without full-scale sum");

  // a result only appears once a hit has finished its sequence
  a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a hit in flight");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("handshake state not cleared by reset");
endmodule

// ===== test/chi_square_checker.sv =====
// chi_square_checker: watches the hit, result and register ports of
// line_fit_chi_square, predicts each result and compares. uses lfcs_pkg.
`timescale 1ns / 1ps
module chi_square_checker #(
  parameter int MAX_HITS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_hit_x,
  input  logic [31:0] in_hit_y,
  input  logic [31:0] in_hit_z,
  input  logic [31:0] in_sigma_x,
  input  logic [31:0] in_sigma_y,
  input  logic [31:0] in_sigma_z,
  input  logic        in_last_hit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [47:0] out_chi_square,
  input  logic        out_is_last,
  input  logic        out_sum_saturated,
  input  logic        out_too_many_hits,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          outstanding
);
  import lfcs_pkg::*;

  typedef struct packed {
    logic [47:0] chi_square;
    logic        is_last;
    logic        sum_saturated;
    logic        too_many_hits;
  } score_t;

  logic [31:0] track_reg [4];
  logic [63:0] running_sum;
  int          hits_in_track;
  logic        sum_clipped;
  score_t      expected_scores [$];

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // q16.16 product, truncated toward zero, magnitude capped
  function automatic longint fix_mul(longint a, longint b);
    logic [127:0] p;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> 16;
    if (p > {64'd0, MAG_CAP}) p = {64'd0, MAG_CAP};
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] fix_div(logic [63:0] n, logic [63:0] den,
                                          logic [63:0] cap);
    logic [127:0] q;
    q = ({64'd0, n} << 16) / {64'd0, den};
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  function automatic longint clamp_cap(longint v);
    if (v > longint'(MAG_CAP)) return longint'(MAG_CAP);
    if (v < -longint'(MAG_CAP)) return -longint'(MAG_CAP);
    return v;
  endfunction

  // bit 64 flags a saturated term
  function automatic logic [64:0] weighted_sq(longint d, logic [31:0] sigma);
    logic [63:0] s, q, sq;
    s = (sigma == 0) ? 64'd1 : {32'd0, sigma};
    q = fix_div(magnitude(d), s, Q_CAP);
    if (q >= Q_CAP) return {1'b1, 14'd0, CHI_MAX};
    sq = (q * q) >> 16;
    return {1'b0, sq};
  endfunction

  task automatic score_hit();
    longint ax, bx, ay, by, x, y, z, s1, s2, s3, num, f, dx, dy, dz;
    logic [64:0] tx, ty, tz;
    logic [63:0] fm, total;
    score_t sc;
    ax = longint'($signed(track_reg[REG_SLOPE_X]));
    bx = longint'($signed(track_reg[REG_OFFSET_X]));
    ay = longint'($signed(track_reg[REG_SLOPE_Y]));
    by = longint'($signed(track_reg[REG_OFFSET_Y]));
    x = longint'($signed(in_hit_x));
    y = longint'($signed(in_hit_y));
    z = longint'($signed(in_hit_z));
    s1 = fix_mul(x, ax) + fix_mul(y, ay) + z;
    s2 = fix_mul(bx, ax) + fix_mul(by, ay);
    s3 = fix_mul(ax, ax) + fix_mul(ay, ay) + 65536;
    num = s1 - s2;
    fm = fix_div(magnitude(num), 64'(s3), MAG_CAP);
    f = (num < 0) ? -longint'(fm) : longint'(fm);
    dx = clamp_cap(bx + fix_mul(f, ax) - x);
    dy = clamp_cap(by + fix_mul(f, ay) - y);
    dz = clamp_cap(f - z);
    tx = weighted_sq(dx, in_sigma_x);
    ty = weighted_sq(dy, in_sigma_y);
    tz = weighted_sq(dz, in_sigma_z);
    total = running_sum + tx[63:0] + ty[63:0] + tz[63:0];
    if (tx[64] || ty[64] || tz[64] || total > 64'(CHI_MAX)) begin
      total = 64'(CHI_MAX);
      sum_clipped = 1'b1;
    end
    running_sum = total;
    if (hits_in_track <= MAX_HITS) hits_in_track++;
    sc.chi_square = total[47:0];
    sc.is_last = in_last_hit;
    sc.sum_saturated = sum_clipped;
    sc.too_many_hits = hits_in_track > MAX_HITS;
    expected_scores.push_back(sc);
    if (in_last_hit) begin
      running_sum = 0;
      hits_in_track = 0;
      sum_clipped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    score_t exp_sc;
    int     fails;
    fails = 0;
    if (!rst_n) begin
      foreach (track_reg[i]) track_reg[i] = '0;
      running_sum = 0;
      hits_in_track = 0;
      sum_clipped = 1'b0;
      expected_scores.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) track_reg[cfg_addr] = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result transaction, chi_square %0h", out_chi_square);
          fails++;
        end else begin
          exp_sc = expected_scores.pop_front();
          if (exp_sc.chi_square !== out_chi_square) begin
            $error("chi_square: expected %0h, actual %0h",
                   exp_sc.chi_square, out_chi_square);
            fails++;
          end
          if (exp_sc.is_last !== out_is_last) begin
            $error("is_last: expected %0b, actual %0b", exp_sc.is_last, out_is_last);
            fails++;
          end
          if (exp_sc.sum_saturated !== out_sum_saturated) begin
            $error("sum_saturated: expected %0b, actual %0b",
                   exp_sc.sum_saturated, out_sum_saturated);
            fails++;
          end
          if (exp_sc.too_many_hits !== out_too_many_hits) begin
            $error("too_many_hits: expected %0b, actual %0b",
                   exp_sc.too_many_hits, out_too_many_hits);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) score_hit();
      errors <= errors + fails;
      outstanding <= expected_scores.size();
    end
  end
endmodule

// ===== test/testbench.sv =====
// testbench: stimulus and verdict for line_fit_chi_square.
// depends on lfcs_pkg, the block and chi_square_checker.
`timescale 1ns / 1ps
module testbench;
  import lfcs_pkg::*;

  localparam int MAX_HITS_TB = 1024;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_hit_x = '0, in_hit_y = '0, in_hit_z = '0;
  logic [31:0] in_sigma_x = '0, in_sigma_y = '0, in_sigma_z = '0;
  logic        in_last_hit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] out_chi_square;
  logic        out_is_last, out_sum_saturated, out_too_many_hits;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  int          errors, outstanding;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          recv_hold = 0;

  always #10 clk = ~clk;

  line_fit_chi_square dut (.*);

  chi_square_checker checker_i (.*);

  // receiver stalls come in stretches so that results wait long enough
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
    end else if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      out_ready <= 1'b0;
      recv_hold <= $urandom_range(0, 400);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: case ($urandom_range(3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'hffff_ffff;
           default: return 32'h0;
         endcase
      default: return 32'(int'($urandom_range(0, 32'h40_0000)) - 32'h20_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_sigma();
    case ($urandom_range(7))
      0: return $urandom_range(1, 32'hffff_ffff);
      1: return 32'd1;
      default: return $urandom_range(256, 32'h10_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_track_param();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'(int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
    endcase
  endfunction

  // called at a rising edge; returns at the edge that takes the transaction
  task automatic send_hit(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                          logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 400)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hit_x <= x;
    in_hit_y <= y;
    in_hit_z <= z;
    in_sigma_x <= sx;
    in_sigma_y <= sy;
    in_sigma_z <= sz;
    in_last_hit <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_random_hit(logic last);
    send_hit(pick_coord(), pick_coord(), pick_coord(),
             pick_sigma(), pick_sigma(), pick_sigma(), last);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_track(logic [31:0] ax, logic [31:0] bx,
                           logic [31:0] ay, logic [31:0] by);
    logic [31:0] vals [4];
    vals[REG_SLOPE_X] = ax;
    vals[REG_OFFSET_X] = bx;
    vals[REG_SLOPE_Y] = ay;
    vals[REG_OFFSET_Y] = by;
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_tracks(int n_hits);
    int sent, len;
    sent = 0;
    while (sent < n_hits) begin
      len = $urandom_range(1, 8);
      for (int j = 0; j < len; j++) begin
        // an occasional early close breaks a track
        send_random_hit(j == len - 1 || $urandom_range(30) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // straight track along z through the origin
    send_hit('0, '0, '0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0);
    send_hit(32'h2_0000, 32'hfffe_0000, 32'h5_0000, 32'h1_0000, 32'h8000,
             32'h1_0000, 1'b0);
    // saturating term, flag must hold until the track closes
    send_hit(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1,
             1'b0);
    send_hit(32'h1000, 32'h1000, '0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1);
    // zero sigma counts as one lsb
    send_hit(32'h10, 32'hffff_fff0, 32'h8000_0000, '0, '0, '0, 1'b0);
    send_hit(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 1'b1);

    set_track(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_hit('0, '0, '0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_hit(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1_0000,
             32'h1_0000, 32'h1_0000, 1'b0);
    send_hit(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd1,
             32'hffff_ffff, 1'b1);

    set_track(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_hit(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_hit(32'h8000_0000, '0, 32'hffff_ffff, 32'h1_0000, 32'h1_0000, 32'd1,
             1'b1);

    set_track(32'h8000, 32'h3_0000, 32'hffff_c000, 32'hfffe_0000);
    send_hit(32'h3_8000, 32'hfffe_0000, 32'h1_0000, 32'h1000, 32'h1000,
             32'h1000, 1'b0);
    send_hit(32'h4_0000, 32'hfffd_8000, 32'h2_0000, 32'h1000, 32'h1000,
             32'h1000, 1'b1);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 76; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 76; end
        default: begin send_idle_pct = 7; recv_idle_pct = 7; end
      endcase
      set_track(pick_track_param(), pick_track_param(),
                pick_track_param(), pick_track_param());
      run_tracks(15);
      set_track(pick_track_param(), pick_track_param(),
                pick_track_param(), pick_track_param());
      run_tracks(15);
    end

    // one track past the hit limit, still summed afterwards
    set_track(32'h4000, 32'h1_0000, 32'hffff_8000, 32'h2_0000);
    for (int j = 0; j < MAX_HITS_TB + 6; j++)
      send_random_hit(j == MAX_HITS_TB + 5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_tracks(4);

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/lfcs_pkg.sv
rtl/lfcs_div.sv
rtl/lfcs_dp.sv
rtl/lfcs_ctrl.sv
rtl/line_fit_chi_square.sv
test/chi_square_checker.sv
test/testbench.sv
